// ===== hw/rtl/bdjm_pkg.sv =====
// Package for the button debounce / joystick mapping block.
// Beat payload types, lane result structs, register indexes and constants.
// No dependencies.
package bdjm_pkg;

    localparam int NUM_BUTTONS = 14;
    localparam int ADC_W       = 12;
    localparam int AXIS_W      = 8;
    localparam int CNT_W       = 4;
    localparam int DZ_W        = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FLIP_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 1'b1;

    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 4'd3;
    localparam logic [DZ_W-1:0]  DEADZONE_RESET  = 7'd0;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] pin_levels;
        logic [ADC_W-1:0]       adc_left_x;
        logic [ADC_W-1:0]       adc_left_y;
        logic [ADC_W-1:0]       adc_right_x;
        logic [ADC_W-1:0]       adc_right_y;
    } bdjm_in_t;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0]    buttons_stable;
        logic signed [AXIS_W-1:0]  left_x;
        logic signed [AXIS_W-1:0]  left_y;
        logic signed [AXIS_W-1:0]  right_x;
        logic signed [AXIS_W-1:0]  right_y;
        logic                      changed;
    } bdjm_out_t;

    // one button lane: debounced state now and after this tick
    typedef struct packed {
        logic stable;
        logic stable_next;
    } bdjm_btn_res_t;

    // one axis lane: mapped value and whether it differs from last tick
    typedef struct packed {
        logic signed [AXIS_W-1:0] value;
        logic                     diff;
    } bdjm_axis_res_t;

endpackage

// ===== hw/rtl/button_debounce_joystick_map.sv =====
// Usage
// -----
// Each sample beat is one sampling tick: 14 active-low button pins and four
// 12-bit stick readings. Each accepted beat yields exactly one result beat:
// debounced buttons (1 = pressed), four axes in -100..99 after deadzone, and
// a changed flag (new press, or any axis differs from the previous tick).
// Channels: sample_valid/sample_ready/sample in, result_valid/result_ready/
// result out. cfg_we/cfg_index/cfg_data write the flip tick count (index 0)
// and deadzone (index 1); write only while idle.
// Each result is registered in the result buffer and leaves it in order.
// Throughput: one beat per cycle while the result buffer has space; every lane finishes
// its tick in the accept cycle, so the button counters and axis history never hold back.
// A two-beat result buffer absorbs stalls: with result_ready low, up to two
// results queue and sample_ready drops only when both slots are full.
// Reset (rst_n low, async): debounced state, counters and axis history clear
// to zero, threshold returns to 3, deadzone to 0, result buffer empties.
// Depends on bdjm_pkg, bdjm_button_lane, bdjm_axis_lane, bdjm_out_buf.
module button_debounce_joystick_map (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bdjm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdjm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  bdjm_pkg::bdjm_in_t                 sample,
    output logic                               result_valid,
    input  logic                               result_ready,
    output bdjm_pkg::bdjm_out_t                result
);
    import bdjm_pkg::*;

    logic [CNT_W-1:0]       threshold_reg;
    logic [DZ_W-1:0]        deadzone_reg;
    logic                   accept;
    logic [NUM_BUTTONS-1:0] btn_cur, btn_next;
    bdjm_btn_res_t          btn_res [NUM_BUTTONS];
    bdjm_axis_res_t         lx_res, ly_res, rx_res, ry_res;
    logic [3:0]             axis_diff;
    bdjm_out_t              merged;

    assign accept = sample_valid && sample_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            deadzone_reg  <= DEADZONE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FLIP_TICKS: threshold_reg <= cfg_data[CNT_W-1:0];
                REG_DEADZONE:   deadzone_reg  <= cfg_data[DZ_W-1:0];
                default:        ;
            endcase
        end
    end

    // button lanes, one per pin
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_btn
        bdjm_button_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .accept    (accept),
            .pin_level (sample.pin_levels[i]),
            .threshold (threshold_reg),
            .res       (btn_res[i])
        );
        assign btn_cur[i]  = btn_res[i].stable;
        assign btn_next[i] = btn_res[i].stable_next;
    end

    // axis lanes
    bdjm_axis_lane u_lx (
        .clk (clk), .rst_n (rst_n), .accept (accept),
        .adc (sample.adc_left_x), .deadzone (deadzone_reg), .res (lx_res)
    );
    bdjm_axis_lane u_ly (
        .clk (clk), .rst_n (rst_n), .accept (accept),
        .adc (sample.adc_left_y), .deadzone (deadzone_reg), .res (ly_res)
    );
    bdjm_axis_lane u_rx (
        .clk (clk), .rst_n (rst_n), .accept (accept),
        .adc (sample.adc_right_x), .deadzone (deadzone_reg), .res (rx_res)
    );
    bdjm_axis_lane u_ry (
        .clk (clk), .rst_n (rst_n), .accept (accept),
        .adc (sample.adc_right_y), .deadzone (deadzone_reg), .res (ry_res)
    );

    assign axis_diff = {ry_res.diff, rx_res.diff, ly_res.diff, lx_res.diff};

    // merge: the previous published buttons equal the current debounced
    // state, so a new press is a bit that sets this tick
    always_comb
    begin
        merged.buttons_stable = btn_next;
        merged.left_x         = lx_res.value;
        merged.left_y         = ly_res.value;
        merged.right_x        = rx_res.value;
        merged.right_y        = ry_res.value;
        merged.changed        = (|(btn_next & ~btn_cur)) || (|axis_diff);
    end

    bdjm_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (merged),
        .space     (sample_ready),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

`ifndef SYNTHESIS
    // input only backs up when results are stuck
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid && !result_ready ||
                          $past(result_valid) && !$past(result_ready))
        else $error("sample channel blocked without output stall");
    // a quiet tick never raises the flag
    a_quiet_tick: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (btn_next == btn_cur) && (axis_diff == 4'b0000) |-> !merged.changed)
        else $error("changed flag set on quiet tick");
    // after an accepted beat, result_valid is always high in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("no result after accepted beat");
`endif

endmodule

// ===== hw/rtl/bdjm_button_lane.sv =====
// One button debounce lane: disagreement counter and debounced state bit.
// Depends on bdjm_pkg.
module bdjm_button_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          pin_level,
    input  logic [bdjm_pkg::CNT_W-1:0]    threshold,
    output bdjm_pkg::bdjm_btn_res_t       res
);
    import bdjm_pkg::*;

    logic             stable_reg, stable_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_inc;
    logic             pressed;

    assign pressed   = ~pin_level;
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        stable_next = stable_reg;
        count_next  = '0;
        if (stable_reg != pressed)
        begin
            if (count_inc >= threshold)
            begin
                stable_next = pressed;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            stable_reg <= stable_next;
            count_reg  <= count_next;
        end
    end

    assign res.stable      = stable_reg;
    assign res.stable_next = stable_next;

`ifndef SYNTHESIS
    // a flip always restarts the count
    a_flip_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (stable_next != stable_reg) |=> count_reg == '0)
        else $error("button counter not cleared after flip");
    // threshold is at most 15, so the counter flips before it saturates
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != {CNT_W{1'b1}})
        else $error("button counter reached all ones");
    // state only moves on an accepted tick
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(stable_reg) && $stable(count_reg))
        else $error("button state moved without a beat");
`endif

endmodule

// ===== hw/rtl/bdjm_axis_lane.sv =====
// One joystick axis lane: centers, scales to percent, clamps, applies deadzone.
// Keeps last tick's value for change detection. Depends on bdjm_pkg.
module bdjm_axis_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [bdjm_pkg::ADC_W-1:0]    adc,
    input  logic [bdjm_pkg::DZ_W-1:0]     deadzone,
    output bdjm_pkg::bdjm_axis_res_t      res
);
    import bdjm_pkg::*;

    logic signed [13:0]       centered;
    logic signed [20:0]       prod;
    logic signed [20:0]       biased;
    logic signed [9:0]        quot;
    logic signed [9:0]        clamped;
    logic [9:0]               mag;
    logic signed [AXIS_W-1:0] axis;
    logic signed [AXIS_W-1:0] prev_reg;

    always_comb
    begin
        centered = $signed({2'b00, adc}) - 14'sd2048;
        prod     = {{7{centered[13]}}, centered} * 21'sd100;
        // arithmetic shift floors; bias negatives so it truncates toward zero
        biased   = prod + (prod[20] ? 21'sd2047 : 21'sd0);
        quot     = 10'(biased >>> 11);
        if (quot > 10'sd100)
        begin
            clamped = 10'sd99;
        end
        else if (quot < -10'sd100)
        begin
            clamped = -10'sd99;
        end
        else
        begin
            clamped = quot;
        end
        mag  = clamped[9] ? 10'(-clamped) : clamped;
        axis = (mag < {3'b000, deadzone}) ? '0 : clamped[AXIS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (accept)
        begin
            prev_reg <= axis;
        end
    end

    assign res.value = axis;
    assign res.diff  = (axis != prev_reg);

endmodule

// ===== hw/rtl/bdjm_out_buf.sv =====
// Two-entry result buffer between the lanes and the result channel.
// Lets a beat enter while an earlier one stalls. Depends on bdjm_pkg.
module bdjm_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bdjm_pkg::bdjm_out_t   push_data,
    output logic                  space,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bdjm_pkg::bdjm_out_t   out_data
);
    import bdjm_pkg::*;

    bdjm_out_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("result buffer overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("result buffer pointers inconsistent");
`endif

endmodule
